[hw/rtl/pcm_pkg.sv]
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants of the palette nearest-colour mapper: word
// layouts, command and register codes, distance weights and widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pcm_pkg;

    // Palette size and derived widths
    localparam int PALETTE_ENTRIES = 256;
    localparam int ENTRY_W         = $clog2(PALETTE_ENTRIES);
    localparam int COLOR_W         = 8;
    localparam int RGB_W           = 3 * COLOR_W;

    // Fixed-point channel weights (over 256): 0.30, 0.59, 0.11
    localparam logic [COLOR_W-1:0] WEIGHT_RED   = 8'd77;
    localparam logic [COLOR_W-1:0] WEIGHT_GREEN = 8'd151;
    localparam logic [COLOR_W-1:0] WEIGHT_BLUE  = 8'd28;

    // Distance widths: scaled difference, its square, and the three-term sum
    localparam int SCALED_W = 2 * COLOR_W;
    localparam int SQ_W     = 2 * SCALED_W;
    localparam int DIST_W   = 31;

    localparam logic [7:0] TRANSPARENT_INDEX = 8'd255;
    localparam logic [7:0] ALPHA_THR_RESET   = 8'd8;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    // Register file: byte address 4*i, index taken from paddr[2]
    localparam int   ADDR_W              = 3;
    localparam logic REG_ALPHA_THRESHOLD = 1'b0;

    // Input word
    typedef struct packed {
        logic       command;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [7:0] color_index;
        logic       transparent;
    } t_out_word;

    // Sideband travelling with each palette entry through the distance pipe
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [ENTRY_W-1:0] idx;
    } t_tag;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/pcm_dist.sv]
// ----------------------------------------------------------------------------
// pcm_dist
// Three-stage weighted squared distance pipe: scale the absolute channel
// differences, square them, then sum. Each entry carries its tag along.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_dist (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pcm_pkg::t_tag                 i_tag,
    input  wire logic [pcm_pkg::RGB_W-1:0]     i_entry,
    input  wire logic [pcm_pkg::COLOR_W-1:0]   i_red,
    input  wire logic [pcm_pkg::COLOR_W-1:0]   i_green,
    input  wire logic [pcm_pkg::COLOR_W-1:0]   i_blue,
    output pcm_pkg::t_tag                      o_tag,
    output logic [pcm_pkg::DIST_W-1:0]         o_dist
);

    logic [pcm_pkg::COLOR_W-1:0]  pr, pg, pb;
    logic [pcm_pkg::COLOR_W-1:0]  dr, dg, db;
    pcm_pkg::t_tag                r_tag2, r_tag3, r_tag4;
    logic [pcm_pkg::SCALED_W-1:0] r_sc_r, r_sc_g, r_sc_b;
    logic [pcm_pkg::SQ_W-1:0]     r_sq_r, r_sq_g, r_sq_b;
    logic [pcm_pkg::DIST_W-1:0]   r_dist;

    // Absolute differences against the held pixel
    assign pr = i_entry[3*pcm_pkg::COLOR_W-1:2*pcm_pkg::COLOR_W];
    assign pg = i_entry[2*pcm_pkg::COLOR_W-1:pcm_pkg::COLOR_W];
    assign pb = i_entry[pcm_pkg::COLOR_W-1:0];
    assign dr = (pr > i_red)   ? (pr - i_red)   : (i_red - pr);
    assign dg = (pg > i_green) ? (pg - i_green) : (i_green - pg);
    assign db = (pb > i_blue)  ? (pb - i_blue)  : (i_blue - pb);

    // Tag shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
        end else begin
            r_tag2 <= i_tag;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
        end
    end

    // Datapath stages: scale, square, sum
    always_ff @(posedge i_clk) begin
        r_sc_r <= pcm_pkg::SCALED_W'(dr * pcm_pkg::WEIGHT_RED);
        r_sc_g <= pcm_pkg::SCALED_W'(dg * pcm_pkg::WEIGHT_GREEN);
        r_sc_b <= pcm_pkg::SCALED_W'(db * pcm_pkg::WEIGHT_BLUE);

        r_sq_r <= pcm_pkg::SQ_W'(r_sc_r * r_sc_r);
        r_sq_g <= pcm_pkg::SQ_W'(r_sc_g * r_sc_g);
        r_sq_b <= pcm_pkg::SQ_W'(r_sc_b * r_sc_b);

        // sum stays below 2^31 for 8-bit channels
        r_dist <= pcm_pkg::DIST_W'(r_sq_r + r_sq_g + r_sq_b);
    end

    assign o_tag  = r_tag4;
    assign o_dist = r_dist;

endmodule

`default_nettype wire

[hw/rtl/palette_nearest_color_mapper.sv]
// ----------------------------------------------------------------------------
// palette_nearest_color_mapper
// Maps RGB pixels to the nearest entry of a stored palette by weighted
// squared distance; write commands load palette entries.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+-----------
//  input    | i_in_valid / o_in_ready / i_in_data       | in
//  result   | o_out_valid / i_out_ready / o_out_data    | out
//  config   | psel penable pwrite paddr pwdata prdata   | APB slave
//
//  A write command loads its palette entry when it is accepted. A map
//  command of an opaque pixel scans the palette, one memory read a cycle;
//  the registered read, the three-stage distance pipe, the running minimum
//  and the output register then put the result word out, and the next
//  word is taken in the same cycle as the result word appears.
//  A transparent pixel skips the scan. A new word is taken while a result
//  still waits in the output register; a finished search holds until that
//  register is free. Reset is synchronous; the palette is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_nearest_color_mapper (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input words
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire pcm_pkg::t_in_word                  i_in_data,
    // result words
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output pcm_pkg::t_out_word                      o_out_data,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pcm_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    localparam logic [pcm_pkg::ENTRY_W-1:0] LAST_ADDR =
        pcm_pkg::ENTRY_W'(pcm_pkg::PALETTE_ENTRIES - 1);

    pcm_pkg::t_state                  r_state, n_state;
    logic                             in_acc;
    logic                             scan_rd;
    logic                             load_out;
    logic                             wr_hit;
    logic                             is_transp;
    logic [7:0]                       r_alpha_thr;
    logic [pcm_pkg::RGB_W-1:0]        mem [pcm_pkg::PALETTE_ENTRIES];
    logic [pcm_pkg::RGB_W-1:0]        r_rd_data;
    logic [pcm_pkg::ENTRY_W-1:0]      r_addr;
    pcm_pkg::t_tag                    r_tag1;
    pcm_pkg::t_tag                    dist_tag;
    logic [pcm_pkg::DIST_W-1:0]       cur_dist;
    logic [pcm_pkg::COLOR_W-1:0]      r_red, r_green, r_blue;
    logic                             r_transp;
    logic [pcm_pkg::DIST_W-1:0]       r_best_dist;
    logic [pcm_pkg::ENTRY_W-1:0]      r_best_idx;
    logic                             r_out_valid;
    pcm_pkg::t_out_word               r_out_data;

    assign in_acc    = i_in_valid & o_in_ready;
    assign is_transp = i_in_data.alpha < r_alpha_thr;
    assign wr_hit    = in_acc && (i_in_data.command == pcm_pkg::CMD_WRITE) &&
                       ({1'b0, i_in_data.entry_index} < 9'(pcm_pkg::PALETTE_ENTRIES));

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_thr <= pcm_pkg::ALPHA_THR_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == pcm_pkg::REG_ALPHA_THRESHOLD) begin
            r_alpha_thr <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == pcm_pkg::REG_ALPHA_THRESHOLD) begin
            prdata = {24'd0, r_alpha_thr};
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        scan_rd    = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            pcm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_in_data.command == pcm_pkg::CMD_MAP) begin
                    n_state = is_transp ? pcm_pkg::ST_DONE : pcm_pkg::ST_SCAN;
                end
            end
            pcm_pkg::ST_SCAN: begin
                scan_rd = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = pcm_pkg::ST_DRAIN;
                end
            end
            pcm_pkg::ST_DRAIN: begin
                if (dist_tag.valid && dist_tag.last) begin
                    n_state = pcm_pkg::ST_DONE;
                end
            end
            pcm_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = pcm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcm_pkg::ST_IDLE;
            end
        endcase
    end

    // Pixel and transparency capture
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.command == pcm_pkg::CMD_MAP) begin
            r_red    <= i_in_data.red;
            r_green  <= i_in_data.green;
            r_blue   <= i_in_data.blue;
            r_transp <= is_transp;
        end
    end

    // Palette memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            mem[i_in_data.entry_index[pcm_pkg::ENTRY_W-1:0]] <=
                {i_in_data.red, i_in_data.green, i_in_data.blue};
        end
        if (scan_rd) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // Scan address counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (scan_rd) begin
            r_addr <= r_addr + pcm_pkg::ENTRY_W'(1);
        end else begin
            r_addr <= '0;
        end
    end

    // Tag for the entry coming out of the memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
        end else begin
            r_tag1.valid <= scan_rd;
            r_tag1.last  <= (r_addr == LAST_ADDR);
            r_tag1.idx   <= r_addr;
        end
    end

    pcm_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag1),
        .i_entry (r_rd_data),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_tag   (dist_tag),
        .o_dist  (cur_dist)
    );

    // Running minimum; entry 0 seeds it, strict compare keeps the first tie
    always_ff @(posedge i_clk) begin
        if (dist_tag.valid && (dist_tag.idx == '0 || cur_dist < r_best_dist)) begin
            r_best_dist <= cur_dist;
            r_best_idx  <= dist_tag.idx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data.color_index <= r_transp ? pcm_pkg::TRANSPARENT_INDEX
                                               : 8'(r_best_idx);
            r_out_data.transparent <= r_transp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
